>>> src/cpb_pkg.sv
// Shared types and constants for the clipped pixel blitter.
// No dependencies; every other file in src/ refers to this package by scoped name.
`default_nettype none

package cpb_pkg;

	// Clip arithmetic width: holds every intermediate of the two clip passes exactly
	localparam int CLIP_BITS = 20;

	localparam int CFG_INDEX_BITS = 3;
	localparam int PIXEL_BITS     = 16;
	localparam int STATUS_BITS    = 2;

	localparam int RESET_BUF_WIDTH  = 320;
	localparam int RESET_BUF_HEIGHT = 240;

	// Command codes carried by the cmd field
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BUF_WIDTH    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BUF_HEIGHT   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BUF_WIDTH  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BUF_HEIGHT = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BIG_ENDIAN = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BIG_ENDIAN   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BASE_WORD  = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BASE_WORD    = 3'd7;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_STARTED     = 2'd0,
		ST_EMPTY       = 2'd1,
		ST_WRITTEN     = 2'd2,
		ST_IDLE_PIXEL  = 2'd3
	} status_t;

	// Rectangle under clipping: primary position is clipped against the bounds,
	// secondary position follows every left/top move of the primary one.
	typedef struct packed {
		logic signed [CLIP_BITS-1:0] px;
		logic signed [CLIP_BITS-1:0] py;
		logic signed [CLIP_BITS-1:0] sx;
		logic signed [CLIP_BITS-1:0] sy;
		logic signed [CLIP_BITS-1:0] w;
		logic signed [CLIP_BITS-1:0] h;
	} clip_rect_t;

	// Control group from the walk stage to the address stage
	typedef struct packed {
		status_t status;
		logic    write_en;
		logic    fetch_en;
		logic    clip_en;
		logic    last;
	} walk_ctl_t;

endpackage

`default_nettype wire

>>> src/clipped_pixel_blitter_top.sv
// Top level of the clipped 16-bit pixel blitter: configuration registers,
// stage handshake and the pipeline of cpb_clip, cpb_walk and cpb_addr (cpb_pkg).
//
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  cmd, req_*, source_pixel
//  out      out        out_valid/out_stall  status, addresses, pixel, clipped_*
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low. A result passes through the input
// register, destination clip, source clip with counter update, then the two address
// multipliers into the result register.
// The four stages advance independently, so input is taken while a result waits;
// in_stall rises only when every stage is full and out_stall is high.
// Reset clears stage valids and blit state and loads the configuration reset values.
`default_nettype none

module clipped_pixel_blitter_top #(
	parameter int DIM_BITS  = 12,
	parameter int ADDR_BITS = 24
) (
	input  logic                                     clk,
	input  logic                                     arst_n,

	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     cmd,
	input  logic signed [15:0]                       req_dest_x,
	input  logic signed [15:0]                       req_dest_y,
	input  logic [14:0]                              req_width,
	input  logic [14:0]                              req_height,
	input  logic signed [15:0]                       req_source_x,
	input  logic signed [15:0]                       req_source_y,
	input  logic [cpb_pkg::PIXEL_BITS-1:0]           source_pixel,

	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic [cpb_pkg::STATUS_BITS-1:0]          status,
	output logic [ADDR_BITS-1:0]                     write_address,
	output logic [cpb_pkg::PIXEL_BITS-1:0]           write_pixel,
	output logic [ADDR_BITS-1:0]                     fetch_address,
	output logic                                     last_pixel,
	output logic [DIM_BITS-1:0]                      clipped_dest_x,
	output logic [DIM_BITS-1:0]                      clipped_dest_y,
	output logic [DIM_BITS-1:0]                      clipped_source_x,
	output logic [DIM_BITS-1:0]                      clipped_source_y,
	output logic [DIM_BITS-1:0]                      clipped_width,
	output logic [DIM_BITS-1:0]                      clipped_height,

	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [cpb_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [((ADDR_BITS > DIM_BITS) ? ADDR_BITS : DIM_BITS)-1:0] cfg_data
);

	// configuration registers
	logic [DIM_BITS-1:0]   dest_buf_width_q, dest_buf_height_q;
	logic [DIM_BITS-1:0]   source_buf_width_q, source_buf_height_q;
	logic                  source_big_q, dest_big_q;
	logic [ADDR_BITS-1:0]  source_base_q, dest_base_q;

	// stage handshake
	logic  v1_q, v2_q, v3_q, vo_q;
	logic  ld1, ld2, ld3, ld_o;

	// stage payload
	logic                            cmd_s1, cmd_s2;
	cpb_pkg::clip_rect_t             rect_s1, rect_s2;
	logic [cpb_pkg::PIXEL_BITS-1:0]  pix_s1, pix_s2;
	cpb_pkg::clip_rect_t             rect_in, dest_clipped, src_in, src_clipped;

	cpb_pkg::walk_ctl_t              ctl_s3;
	logic [DIM_BITS:0]               wr_row_s3, wr_col_s3, fe_row_s3, fe_col_s3;
	logic [cpb_pkg::PIXEL_BITS-1:0]  pix_s3;
	logic [DIM_BITS-1:0]             held_dx, held_dy, held_sx, held_sy, held_w, held_h;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_buf_width_q    <= DIM_BITS'(cpb_pkg::RESET_BUF_WIDTH);
			dest_buf_height_q   <= DIM_BITS'(cpb_pkg::RESET_BUF_HEIGHT);
			source_buf_width_q  <= DIM_BITS'(cpb_pkg::RESET_BUF_WIDTH);
			source_buf_height_q <= DIM_BITS'(cpb_pkg::RESET_BUF_HEIGHT);
			source_big_q        <= 1'b0;
			dest_big_q          <= 1'b0;
			source_base_q       <= '0;
			dest_base_q         <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cpb_pkg::REG_DEST_BUF_WIDTH:    dest_buf_width_q    <= cfg_data[DIM_BITS-1:0];
				cpb_pkg::REG_DEST_BUF_HEIGHT:   dest_buf_height_q   <= cfg_data[DIM_BITS-1:0];
				cpb_pkg::REG_SOURCE_BUF_WIDTH:  source_buf_width_q  <= cfg_data[DIM_BITS-1:0];
				cpb_pkg::REG_SOURCE_BUF_HEIGHT: source_buf_height_q <= cfg_data[DIM_BITS-1:0];
				cpb_pkg::REG_SOURCE_BIG_ENDIAN: source_big_q        <= cfg_data[0];
				cpb_pkg::REG_DEST_BIG_ENDIAN:   dest_big_q          <= cfg_data[0];
				cpb_pkg::REG_SOURCE_BASE_WORD:  source_base_q       <= cfg_data[ADDR_BITS-1:0];
				cpb_pkg::REG_DEST_BASE_WORD:    dest_base_q         <= cfg_data[ADDR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on in the same cycle
	assign ld_o     = v3_q && (!vo_q || !out_stall);
	assign ld3      = v2_q && (!v3_q || ld_o);
	assign ld2      = v1_q && (!v2_q || ld3);
	assign in_stall = v1_q && !ld2;
	assign ld1      = in_valid && !in_stall;
	assign out_valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			v1_q <= ld1 || (v1_q && !ld2);
			v2_q <= ld2 || (v2_q && !ld3);
			v3_q <= ld3 || (v3_q && !ld_o);
			vo_q <= ld_o || (vo_q && out_stall);
		end
	end

	// destination is the primary position for the first clip pass
	always_comb begin
		rect_in.px = cpb_pkg::CLIP_BITS'(req_dest_x);
		rect_in.py = cpb_pkg::CLIP_BITS'(req_dest_y);
		rect_in.sx = cpb_pkg::CLIP_BITS'(req_source_x);
		rect_in.sy = cpb_pkg::CLIP_BITS'(req_source_y);
		rect_in.w  = cpb_pkg::CLIP_BITS'(req_width);
		rect_in.h  = cpb_pkg::CLIP_BITS'(req_height);
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			cmd_s1  <= cmd;
			rect_s1 <= rect_in;
			pix_s1  <= source_pixel;
		end
		if (ld2) begin
			cmd_s2  <= cmd_s1;
			rect_s2 <= dest_clipped;
			pix_s2  <= pix_s1;
		end
	end

	cpb_clip #(
		.DIM_BITS (DIM_BITS)
	) u_clip_dest (
		.rect_in  (rect_s1),
		.bound_w  (dest_buf_width_q),
		.bound_h  (dest_buf_height_q),
		.rect_out (dest_clipped)
	);

	// swap roles so the source position is clipped against its own buffer
	always_comb begin
		src_in.px = rect_s2.sx;
		src_in.py = rect_s2.sy;
		src_in.sx = rect_s2.px;
		src_in.sy = rect_s2.py;
		src_in.w  = rect_s2.w;
		src_in.h  = rect_s2.h;
	end

	cpb_clip #(
		.DIM_BITS (DIM_BITS)
	) u_clip_source (
		.rect_in  (src_in),
		.bound_w  (source_buf_width_q),
		.bound_h  (source_buf_height_q),
		.rect_out (src_clipped)
	);

	cpb_walk #(
		.DIM_BITS (DIM_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld3),
		.cmd       (cmd_s2),
		.rect      (src_clipped),
		.pixel     (pix_s2),
		.swap      (source_big_q != dest_big_q),
		.ctl_s3    (ctl_s3),
		.wr_row_s3 (wr_row_s3),
		.wr_col_s3 (wr_col_s3),
		.fe_row_s3 (fe_row_s3),
		.fe_col_s3 (fe_col_s3),
		.pix_s3    (pix_s3),
		.held_dx_q (held_dx),
		.held_dy_q (held_dy),
		.held_sx_q (held_sx),
		.held_sy_q (held_sy),
		.held_w_q  (held_w),
		.held_h_q  (held_h)
	);

	cpb_addr #(
		.DIM_BITS  (DIM_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_addr (
		.clk              (clk),
		.ld               (ld_o),
		.ctl_s3           (ctl_s3),
		.wr_row_s3        (wr_row_s3),
		.wr_col_s3        (wr_col_s3),
		.fe_row_s3        (fe_row_s3),
		.fe_col_s3        (fe_col_s3),
		.pix_s3           (pix_s3),
		.held_dx          (held_dx),
		.held_dy          (held_dy),
		.held_sx          (held_sx),
		.held_sy          (held_sy),
		.held_w           (held_w),
		.held_h           (held_h),
		.dest_pitch       (dest_buf_width_q),
		.source_pitch     (source_buf_width_q),
		.dest_base        (dest_base_q),
		.source_base      (source_base_q),
		.status           (status),
		.write_address    (write_address),
		.write_pixel      (write_pixel),
		.fetch_address    (fetch_address),
		.last_pixel       (last_pixel),
		.clipped_dest_x   (clipped_dest_x),
		.clipped_dest_y   (clipped_dest_y),
		.clipped_source_x (clipped_source_x),
		.clipped_source_y (clipped_source_y),
		.clipped_width    (clipped_width),
		.clipped_height   (clipped_height)
	);

endmodule

`default_nettype wire

>>> src/cpb_clip.sv
// One clip pass: left, top, right and bottom against one buffer.
// Depends on cpb_pkg (clip_rect_t, CLIP_BITS).
`default_nettype none

module cpb_clip #(
	parameter int DIM_BITS = 12
) (
	input  cpb_pkg::clip_rect_t  rect_in,
	input  logic [DIM_BITS-1:0]  bound_w,
	input  logic [DIM_BITS-1:0]  bound_h,
	output cpb_pkg::clip_rect_t  rect_out
);

	logic signed [cpb_pkg::CLIP_BITS-1:0] bw;
	logic signed [cpb_pkg::CLIP_BITS-1:0] bh;

	assign bw = cpb_pkg::CLIP_BITS'(bound_w);
	assign bh = cpb_pkg::CLIP_BITS'(bound_h);

	always_comb begin
		rect_out = rect_in;
		// left and top clips move both positions and shrink the size
		if (rect_out.px < 0) begin
			rect_out.sx = rect_out.sx - rect_out.px;
			rect_out.w  = rect_out.w + rect_out.px;
			rect_out.px = '0;
		end
		if (rect_out.py < 0) begin
			rect_out.sy = rect_out.sy - rect_out.py;
			rect_out.h  = rect_out.h + rect_out.py;
			rect_out.py = '0;
		end
		if (rect_out.px + rect_out.w > bw) begin
			rect_out.w = bw - rect_out.px;
		end
		if (rect_out.py + rect_out.h > bh) begin
			rect_out.h = bh - rect_out.py;
		end
	end

endmodule

`default_nettype wire

>>> src/cpb_walk.sv
// Blit state: active flag, pixel counters and held rectangle; builds the
// row/column terms of both addresses. Depends on cpb_pkg.
`default_nettype none

module cpb_walk #(
	parameter int DIM_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               ld,
	input  logic                               cmd,
	input  cpb_pkg::clip_rect_t                rect,
	input  logic [cpb_pkg::PIXEL_BITS-1:0]     pixel,
	input  logic                               swap,
	output cpb_pkg::walk_ctl_t                 ctl_s3,
	output logic [DIM_BITS:0]                  wr_row_s3,
	output logic [DIM_BITS:0]                  wr_col_s3,
	output logic [DIM_BITS:0]                  fe_row_s3,
	output logic [DIM_BITS:0]                  fe_col_s3,
	output logic [cpb_pkg::PIXEL_BITS-1:0]     pix_s3,
	output logic [DIM_BITS-1:0]                held_dx_q,
	output logic [DIM_BITS-1:0]                held_dy_q,
	output logic [DIM_BITS-1:0]                held_sx_q,
	output logic [DIM_BITS-1:0]                held_sy_q,
	output logic [DIM_BITS-1:0]                held_w_q,
	output logic [DIM_BITS-1:0]                held_h_q
);

	logic                 active_q, active_d;
	logic [DIM_BITS-1:0]  col_q, col_d, row_q, row_d;
	logic [DIM_BITS-1:0]  held_dx_d, held_dy_d, held_sx_d, held_sy_d, held_w_d, held_h_d;
	logic [DIM_BITS-1:0]  col_inc, col_n, row_n;
	logic                 col_wrap, done, empty;

	cpb_pkg::walk_ctl_t              ctl_d;
	logic [DIM_BITS:0]               wr_row_d, wr_col_d, fe_row_d, fe_col_d;
	logic [cpb_pkg::PIXEL_BITS-1:0]  pix_d;

	assign col_inc  = col_q + 1'b1;
	assign col_wrap = (col_inc >= held_w_q);
	assign col_n    = col_wrap ? '0 : col_inc;
	assign row_n    = col_wrap ? row_q + 1'b1 : row_q;
	assign done     = (row_n >= held_h_q);
	assign empty    = (rect.w <= 0) || (rect.h <= 0);

	always_comb begin
		ctl_d     = '0;
		wr_row_d  = '0;
		wr_col_d  = '0;
		fe_row_d  = '0;
		fe_col_d  = '0;
		pix_d     = '0;
		active_d  = active_q;
		col_d     = col_q;
		row_d     = row_q;
		held_dx_d = held_dx_q;
		held_dy_d = held_dy_q;
		held_sx_d = held_sx_q;
		held_sy_d = held_sy_q;
		held_w_d  = held_w_q;
		held_h_d  = held_h_q;
		if (cmd == cpb_pkg::CMD_START) begin
			col_d = '0;
			row_d = '0;
			if (empty) begin
				active_d     = 1'b0;
				ctl_d.status = cpb_pkg::ST_EMPTY;
			end else begin
				// rect arrives with the source as primary position
				held_sx_d      = rect.px[DIM_BITS-1:0];
				held_sy_d      = rect.py[DIM_BITS-1:0];
				held_dx_d      = rect.sx[DIM_BITS-1:0];
				held_dy_d      = rect.sy[DIM_BITS-1:0];
				held_w_d       = rect.w[DIM_BITS-1:0];
				held_h_d       = rect.h[DIM_BITS-1:0];
				active_d       = 1'b1;
				ctl_d.status   = cpb_pkg::ST_STARTED;
				ctl_d.fetch_en = 1'b1;
				ctl_d.clip_en  = 1'b1;
				fe_row_d       = {1'b0, rect.py[DIM_BITS-1:0]};
				fe_col_d       = {1'b0, rect.px[DIM_BITS-1:0]};
			end
		end else if (!active_q) begin
			ctl_d.status = cpb_pkg::ST_IDLE_PIXEL;
		end else begin
			ctl_d.status   = cpb_pkg::ST_WRITTEN;
			ctl_d.write_en = 1'b1;
			pix_d          = swap ? {pixel[7:0], pixel[15:8]} : pixel;
			wr_row_d       = {1'b0, held_dy_q} + {1'b0, row_q};
			wr_col_d       = {1'b0, held_dx_q} + {1'b0, col_q};
			if (done) begin
				active_d   = 1'b0;
				col_d      = '0;
				row_d      = '0;
				ctl_d.last = 1'b1;
			end else begin
				ctl_d.fetch_en = 1'b1;
				fe_row_d       = {1'b0, held_sy_q} + {1'b0, row_n};
				fe_col_d       = {1'b0, held_sx_q} + {1'b0, col_n};
				col_d          = col_n;
				row_d          = row_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (ld) begin
			active_q <= active_d;
			col_q    <= col_d;
			row_q    <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			held_dx_q <= held_dx_d;
			held_dy_q <= held_dy_d;
			held_sx_q <= held_sx_d;
			held_sy_q <= held_sy_d;
			held_w_q  <= held_w_d;
			held_h_q  <= held_h_d;
			ctl_s3    <= ctl_d;
			wr_row_s3 <= wr_row_d;
			wr_col_s3 <= wr_col_d;
			fe_row_s3 <= fe_row_d;
			fe_col_s3 <= fe_col_d;
			pix_s3    <= pix_d;
		end
	end

endmodule

`default_nettype wire

>>> src/cpb_addr.sv
// Address stage: base + row * pitch + column for both buffers, and the
// result register. Depends on cpb_pkg (walk_ctl_t, PIXEL_BITS, STATUS_BITS).
`default_nettype none

module cpb_addr #(
	parameter int DIM_BITS  = 12,
	parameter int ADDR_BITS = 24
) (
	input  logic                                clk,
	input  logic                                ld,
	input  cpb_pkg::walk_ctl_t                  ctl_s3,
	input  logic [DIM_BITS:0]                   wr_row_s3,
	input  logic [DIM_BITS:0]                   wr_col_s3,
	input  logic [DIM_BITS:0]                   fe_row_s3,
	input  logic [DIM_BITS:0]                   fe_col_s3,
	input  logic [cpb_pkg::PIXEL_BITS-1:0]      pix_s3,
	input  logic [DIM_BITS-1:0]                 held_dx,
	input  logic [DIM_BITS-1:0]                 held_dy,
	input  logic [DIM_BITS-1:0]                 held_sx,
	input  logic [DIM_BITS-1:0]                 held_sy,
	input  logic [DIM_BITS-1:0]                 held_w,
	input  logic [DIM_BITS-1:0]                 held_h,
	input  logic [DIM_BITS-1:0]                 dest_pitch,
	input  logic [DIM_BITS-1:0]                 source_pitch,
	input  logic [ADDR_BITS-1:0]                dest_base,
	input  logic [ADDR_BITS-1:0]                source_base,
	output logic [cpb_pkg::STATUS_BITS-1:0]     status,
	output logic [ADDR_BITS-1:0]                write_address,
	output logic [cpb_pkg::PIXEL_BITS-1:0]      write_pixel,
	output logic [ADDR_BITS-1:0]                fetch_address,
	output logic                                last_pixel,
	output logic [DIM_BITS-1:0]                 clipped_dest_x,
	output logic [DIM_BITS-1:0]                 clipped_dest_y,
	output logic [DIM_BITS-1:0]                 clipped_source_x,
	output logic [DIM_BITS-1:0]                 clipped_source_y,
	output logic [DIM_BITS-1:0]                 clipped_width,
	output logic [DIM_BITS-1:0]                 clipped_height
);

	localparam int PROD_BITS = 2 * DIM_BITS + 2;
	localparam int SUM_BITS  = (ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS;

	logic [SUM_BITS-1:0]  wr_sum, fe_sum;

	assign wr_sum = SUM_BITS'(dest_base) + SUM_BITS'(wr_row_s3) * SUM_BITS'(dest_pitch)
		+ SUM_BITS'(wr_col_s3);
	assign fe_sum = SUM_BITS'(source_base) + SUM_BITS'(fe_row_s3) * SUM_BITS'(source_pitch)
		+ SUM_BITS'(fe_col_s3);

	always_ff @(posedge clk) begin
		if (ld) begin
			status           <= ctl_s3.status;
			write_address    <= ctl_s3.write_en ? wr_sum[ADDR_BITS-1:0] : '0;
			write_pixel      <= pix_s3;
			fetch_address    <= ctl_s3.fetch_en ? fe_sum[ADDR_BITS-1:0] : '0;
			last_pixel       <= ctl_s3.last;
			clipped_dest_x   <= ctl_s3.clip_en ? held_dx : '0;
			clipped_dest_y   <= ctl_s3.clip_en ? held_dy : '0;
			clipped_source_x <= ctl_s3.clip_en ? held_sx : '0;
			clipped_source_y <= ctl_s3.clip_en ? held_sy : '0;
			clipped_width    <= ctl_s3.clip_en ? held_w : '0;
			clipped_height   <= ctl_s3.clip_en ? held_h : '0;
		end
	end

endmodule

`default_nettype wire

>>> tb/clipped_pixel_blitter_top_test.sv
// Self-checking bench for clipped_pixel_blitter_top: clipping of blit requests and the
// pixel walk, checked against an in-bench predictor under random valid and stall idling.
// Depends on cpb_pkg and the blitter RTL only.

module clipped_pixel_blitter_top_test;

	localparam int DIM_W        = 12;
	localparam int ADDR_W       = 24;
	localparam int PIPE_LATENCY = 3;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic               cmd;
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic [14:0]        width;
		logic [14:0]        height;
		logic signed [15:0] source_x;
		logic signed [15:0] source_y;
		logic [15:0]        pixel;
	} blit_item_t;

	typedef struct packed {
		cpb_pkg::status_t   status;
		logic [ADDR_W-1:0]  write_address;
		logic [15:0]        write_pixel;
		logic [ADDR_W-1:0]  fetch_address;
		logic               last_pixel;
		logic [DIM_W-1:0]   dest_x;
		logic [DIM_W-1:0]   dest_y;
		logic [DIM_W-1:0]   source_x;
		logic [DIM_W-1:0]   source_y;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
	} blit_result_t;

	typedef struct {
		longint dx, dy, sx, sy, w, h;
	} clip_window_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               cmd = 1'b0;
	logic signed [15:0] req_dest_x = '0;
	logic signed [15:0] req_dest_y = '0;
	logic [14:0]        req_width = '0;
	logic [14:0]        req_height = '0;
	logic signed [15:0] req_source_x = '0;
	logic signed [15:0] req_source_y = '0;
	logic [15:0]        source_pixel = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [ADDR_W-1:0]  write_address;
	logic [15:0]        write_pixel;
	logic [ADDR_W-1:0]  fetch_address;
	logic               last_pixel;
	logic [DIM_W-1:0]   clipped_dest_x;
	logic [DIM_W-1:0]   clipped_dest_y;
	logic [DIM_W-1:0]   clipped_source_x;
	logic [DIM_W-1:0]   clipped_source_y;
	logic [DIM_W-1:0]   clipped_width;
	logic [DIM_W-1:0]   clipped_height;

	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [ADDR_W-1:0]  cfg_data = '0;

	clipped_pixel_blitter_top dut (.*);

	always #2 clk = ~clk;

	// Predictor copy of the registers and the blit state
	logic [DIM_W-1:0]  dest_buf_w = 12'd320;
	logic [DIM_W-1:0]  dest_buf_h = 12'd240;
	logic [DIM_W-1:0]  source_buf_w = 12'd320;
	logic [DIM_W-1:0]  source_buf_h = 12'd240;
	logic              source_be = 1'b0;
	logic              dest_be = 1'b0;
	logic [ADDR_W-1:0] source_base = '0;
	logic [ADDR_W-1:0] dest_base = '0;

	logic              blit_on = 1'b0;
	logic [DIM_W-1:0]  col_count = '0;
	logic [DIM_W-1:0]  row_count = '0;
	logic [DIM_W-1:0]  held_dx = '0;
	logic [DIM_W-1:0]  held_dy = '0;
	logic [DIM_W-1:0]  held_sx = '0;
	logic [DIM_W-1:0]  held_sy = '0;
	logic [DIM_W-1:0]  held_w = '0;
	logic [DIM_W-1:0]  held_h = '0;

	blit_item_t   request_queue[$];
	blit_result_t awaited_results[$];
	int           queued_count = 0;
	int           accepted_count = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;
	logic         in_taken = 1'b0;
	bit           steady_run = 1'b0;

	// Clip against the destination, then against the source, on wide signed values
	function automatic clip_window_t clip_request(blit_item_t it);
		clip_window_t c;
		longint       cut;
		c.dx = longint'($signed(it.dest_x));
		c.dy = longint'($signed(it.dest_y));
		c.sx = longint'($signed(it.source_x));
		c.sy = longint'($signed(it.source_y));
		c.w  = longint'(it.width);
		c.h  = longint'(it.height);
		if (c.dx < 0) begin
			cut = -c.dx; c.dx += cut; c.sx += cut; c.w -= cut;
		end
		if (c.dy < 0) begin
			cut = -c.dy; c.dy += cut; c.sy += cut; c.h -= cut;
		end
		if (c.dx + c.w > longint'(dest_buf_w)) c.w -= c.dx + c.w - longint'(dest_buf_w);
		if (c.dy + c.h > longint'(dest_buf_h)) c.h -= c.dy + c.h - longint'(dest_buf_h);
		if (c.sx < 0) begin
			cut = -c.sx; c.dx += cut; c.sx += cut; c.w -= cut;
		end
		if (c.sy < 0) begin
			cut = -c.sy; c.dy += cut; c.sy += cut; c.h -= cut;
		end
		if (c.sx + c.w > longint'(source_buf_w)) c.w -= c.sx + c.w - longint'(source_buf_w);
		if (c.sy + c.h > longint'(source_buf_h)) c.h -= c.sy + c.h - longint'(source_buf_h);
		return c;
	endfunction

	function automatic logic [ADDR_W-1:0] word_address(logic [ADDR_W-1:0] base,
			logic [63:0] row, logic [DIM_W-1:0] pitch, logic [63:0] col);
		logic [63:0] sum;
		sum = 64'(base) + row * 64'(pitch) + col;
		return sum[ADDR_W-1:0];
	endfunction

	function automatic blit_result_t step_blitter(blit_item_t it);
		blit_result_t r;
		clip_window_t c;
		logic [15:0]  px;
		r = '0;
		if (it.cmd == cpb_pkg::CMD_START) begin
			c = clip_request(it);
			col_count = '0;
			row_count = '0;
			if (c.w <= 0 || c.h <= 0) begin
				blit_on = 1'b0;
				r.status = cpb_pkg::ST_EMPTY;
			end else begin
				held_dx = c.dx[DIM_W-1:0];
				held_dy = c.dy[DIM_W-1:0];
				held_sx = c.sx[DIM_W-1:0];
				held_sy = c.sy[DIM_W-1:0];
				held_w = c.w[DIM_W-1:0];
				held_h = c.h[DIM_W-1:0];
				blit_on = 1'b1;
				r.status = cpb_pkg::ST_STARTED;
				r.fetch_address = word_address(source_base, 64'(held_sy), source_buf_w,
					64'(held_sx));
				r.dest_x = held_dx;
				r.dest_y = held_dy;
				r.source_x = held_sx;
				r.source_y = held_sy;
				r.width = held_w;
				r.height = held_h;
			end
		end else if (!blit_on) begin
			r.status = cpb_pkg::ST_IDLE_PIXEL;
		end else begin
			px = it.pixel;
			if (source_be != dest_be) px = {px[7:0], px[15:8]};
			r.status = cpb_pkg::ST_WRITTEN;
			r.write_address = word_address(dest_base, 64'(held_dy) + 64'(row_count),
				dest_buf_w, 64'(held_dx) + 64'(col_count));
			r.write_pixel = px;
			col_count = col_count + 1'b1;
			if (col_count >= held_w) begin
				col_count = '0;
				row_count = row_count + 1'b1;
			end
			if (row_count >= held_h) begin
				blit_on = 1'b0;
				col_count = '0;
				row_count = '0;
				r.last_pixel = 1'b1;
			end else begin
				r.fetch_address = word_address(source_base, 64'(held_sy) + 64'(row_count),
					source_buf_w, 64'(held_sx) + 64'(col_count));
			end
		end
		return r;
	endfunction

	task automatic compare_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// Input driver: hold a stalled transaction, otherwise idle for a random gap or advance through the queue
	always @(negedge clk) begin
		blit_item_t it;
		static int send_gap = 0;
		if (in_valid && !in_taken) begin
		end else if (send_gap != 0) begin
			in_valid <= 1'b0;
			send_gap--;
		end else if (request_queue.size() != 0) begin
			it = request_queue.pop_front();
			cmd <= it.cmd;
			req_dest_x <= it.dest_x;
			req_dest_y <= it.dest_y;
			req_width <= it.width;
			req_height <= it.height;
			req_source_x <= it.source_x;
			req_source_y <= it.source_y;
			source_pixel <= it.pixel;
			in_valid <= 1'b1;
			if (!steady_run && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 4);
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		static int stall_gap = 0;
		if (stall_gap != 0) begin
			out_stall <= 1'b1;
			stall_gap--;
		end else if (!steady_run && $urandom_range(0, 9) == 0) begin
			out_stall <= 1'b1;
			stall_gap = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: register writes, accepted inputs and accepted results
	always @(posedge clk) begin
		blit_item_t   seen;
		blit_result_t want;
		cycle_count <= cycle_count + 1;
		in_taken <= in_valid && !in_stall;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cpb_pkg::REG_DEST_BUF_WIDTH:    dest_buf_w = cfg_data[DIM_W-1:0];
				cpb_pkg::REG_DEST_BUF_HEIGHT:   dest_buf_h = cfg_data[DIM_W-1:0];
				cpb_pkg::REG_SOURCE_BUF_WIDTH:  source_buf_w = cfg_data[DIM_W-1:0];
				cpb_pkg::REG_SOURCE_BUF_HEIGHT: source_buf_h = cfg_data[DIM_W-1:0];
				cpb_pkg::REG_SOURCE_BIG_ENDIAN: source_be = cfg_data[0];
				cpb_pkg::REG_DEST_BIG_ENDIAN:   dest_be = cfg_data[0];
				cpb_pkg::REG_SOURCE_BASE_WORD:  source_base = cfg_data;
				cpb_pkg::REG_DEST_BASE_WORD:    dest_base = cfg_data;
				default: ;
			endcase
		end
		if (in_valid && !in_stall) begin
			seen = {cmd, req_dest_x, req_dest_y, req_width, req_height, req_source_x,
				req_source_y, source_pixel};
			awaited_results.push_back(step_blitter(seen));
			accepted_count++;
		end
		if (out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, status %0d", $time, status);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				compare_field("status", 32'(want.status), 32'(status));
				compare_field("write_address", 32'(want.write_address),
					32'(write_address));
				compare_field("write_pixel", 32'(want.write_pixel), 32'(write_pixel));
				compare_field("fetch_address", 32'(want.fetch_address),
					32'(fetch_address));
				compare_field("last_pixel", 32'(want.last_pixel), 32'(last_pixel));
				compare_field("clipped_dest_x", 32'(want.dest_x), 32'(clipped_dest_x));
				compare_field("clipped_dest_y", 32'(want.dest_y), 32'(clipped_dest_y));
				compare_field("clipped_source_x", 32'(want.source_x),
					32'(clipped_source_x));
				compare_field("clipped_source_y", 32'(want.source_y),
					32'(clipped_source_y));
				compare_field("clipped_width", 32'(want.width), 32'(clipped_width));
				compare_field("clipped_height", 32'(want.height), 32'(clipped_height));
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("clipped_pixel_blitter_top test failed");
		$finish;
	end

	function automatic blit_item_t random_item();
		blit_item_t   it;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(blit_item_t)-1:0];
		return it;
	endfunction

	function automatic blit_item_t make_start(int dx, int dy, int w, int h, int sx, int sy);
		blit_item_t it;
		it = random_item();
		it.cmd = cpb_pkg::CMD_START;
		it.dest_x = dx[15:0];
		it.dest_y = dy[15:0];
		it.width = w[14:0];
		it.height = h[14:0];
		it.source_x = sx[15:0];
		it.source_y = sy[15:0];
		return it;
	endfunction

	// Mostly near either buffer edge so that every clip fires
	function automatic int near_edge(int span);
		case ($urandom_range(0, 2))
			0: return int'($urandom_range(0, 16)) - 8;
			1: return span + int'($urandom_range(0, 16)) - 8;
			default: return int'($urandom_range(0, span + 16)) - 8;
		endcase
	endfunction

	task automatic push_item(input blit_item_t it);
		request_queue.push_back(it);
		queued_count++;
	endtask

	task automatic push_pixels(input int count);
		blit_item_t it;
		repeat (count) begin
			it = random_item();
			it.cmd = cpb_pkg::CMD_PIXEL;
			push_item(it);
		end
	endtask

	task automatic push_pixel(input logic [15:0] value);
		blit_item_t it;
		it = random_item();
		it.cmd = cpb_pkg::CMD_PIXEL;
		it.pixel = value;
		push_item(it);
	endtask

	task automatic write_register(input logic [2:0] index, input logic [ADDR_W-1:0] value,
			input int bits);
		logic [ADDR_W-1:0] mask;
		mask = (24'd1 << bits) - 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		// Junk above the register width must be dropped
		cfg_data <= (ADDR_W'($urandom) & ~mask) | (value & mask);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure_buffers(input int dw, input int dh, input int sw, input int sh,
			input bit sbe, input bit dbe, input logic [ADDR_W-1:0] sbase,
			input logic [ADDR_W-1:0] dbase);
		write_register(cpb_pkg::REG_DEST_BUF_WIDTH, ADDR_W'(dw), DIM_W);
		write_register(cpb_pkg::REG_DEST_BUF_HEIGHT, ADDR_W'(dh), DIM_W);
		write_register(cpb_pkg::REG_SOURCE_BUF_WIDTH, ADDR_W'(sw), DIM_W);
		write_register(cpb_pkg::REG_SOURCE_BUF_HEIGHT, ADDR_W'(sh), DIM_W);
		write_register(cpb_pkg::REG_SOURCE_BIG_ENDIAN, ADDR_W'(sbe), 1);
		write_register(cpb_pkg::REG_DEST_BIG_ENDIAN, ADDR_W'(dbe), 1);
		write_register(cpb_pkg::REG_SOURCE_BASE_WORD, sbase, ADDR_W);
		write_register(cpb_pkg::REG_DEST_BASE_WORD, dbase, ADDR_W);
	endtask

	task automatic wait_for_drain();
		do @(negedge clk);
		while (accepted_count != queued_count || awaited_results.size() != 0);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	// Mostly complete blits, some cut short by the next start, plus stray pixels
	task automatic run_random_phase(input int budget);
		int           done;
		int           kind;
		int           npix;
		blit_item_t   it;
		clip_window_t c;
		done = 0;
		while (done < budget) begin
			kind = $urandom_range(0, 19);
			if (kind < 3) begin
				push_pixels(1);
				done += 1;
			end else begin
				if (kind < 16)
					it = make_start(near_edge(int'(dest_buf_w)), near_edge(int'(dest_buf_h)),
						$urandom_range(0, 10), $urandom_range(0, 10),
						near_edge(int'(source_buf_w)), near_edge(int'(source_buf_h)));
				else begin
					it = random_item();
					it.cmd = cpb_pkg::CMD_START;
				end
				c = clip_request(it);
				npix = (c.w > 0 && c.h > 0) ? int'(c.w * c.h) : 0;
				if (npix > 160) npix = $urandom_range(1, 8);
				if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, npix);
				push_item(it);
				push_pixels(npix);
				done += 1 + npix;
			end
		end
		wait_for_drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset register values
		push_pixel(16'hFFFF);
		push_item(make_start(10, 5, 3, 2, 0, 0));
		push_pixel(16'h0000);
		push_pixel(16'hFFFF);
		push_pixel(16'hA55A);
		push_pixel(16'h5AA5);
		push_pixel(16'h1234);
		push_pixel(16'h8001);
		push_item(make_start(-2, -1, 4, 2, 5, 5));
		push_pixels(2);
		push_item(make_start(318, 238, 10, 10, -3, -4));
		push_item(make_start(0, 0, 32767, 32767, 0, 0));
		push_pixels(2);
		push_item(make_start(100, 100, 1, 1, 319, 239));
		push_pixels(1);
		push_item(make_start(-32768, -32768, 32767, 32767, 32767, 32767));
		push_item(make_start(32767, 32767, 0, 0, -1, -1));
		push_item(make_start(5, 5, 7, 0, 5, 5));
		push_item(make_start(0, 0, 1, 1, -32768, 32767));
		push_pixel(16'h00FF);
		wait_for_drain();

		configure_buffers(4095, 4095, 4095, 4095, 1'b1, 1'b0, 24'hFFFFFF, 24'hFFFFFF);
		run_random_phase(90);
		configure_buffers(0, 0, 0, 0, 1'b1, 1'b1, 24'h000000, 24'h000000);
		run_random_phase(30);
		configure_buffers(1, 1, 1, 1, 1'b0, 1'b1, ADDR_W'($urandom), ADDR_W'($urandom));
		run_random_phase(60);
		for (int phase = 0; phase < 5; phase++) begin
			configure_buffers(
				($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 40),
				($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 40),
				($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 40),
				($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 40),
				1'($urandom), 1'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
			// Run the final phase without any idling
			if (phase == 4) steady_run = 1'b1;
			run_random_phase(110);
		end

		if (mismatch_count == 0)
			$display("clipped_pixel_blitter_top test passed");
		else
			$display("clipped_pixel_blitter_top test failed");
		$finish;
	end

endmodule
